// ===== src/psadpcm_pkg.sv =====
package psadpcm_pkg;

  localparam int DEF_CHANNELS = 8;

  localparam int CH_PORT_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 8;
  localparam int PROD_W    = 24;
  localparam int PSUM_W    = 25;
  localparam int PRED_W    = PSUM_W - 6;
  localparam int SUM_W     = 20;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_FIRST  = 4'd2;
  localparam logic [3:0] POS_LAST   = 4'd15;
  localparam logic [2:0] FLAGS_MUTE = 3'h7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_MUL0,
    S_SUM0,
    S_MUL1,
    S_SUM1
  } state_t;

  typedef struct packed {
    logic take;
    logic head;
    logic mul;
    logic sum;
    logic hi_nibble;
  } cmd_t;

  typedef struct packed {
    logic has_samples;
    logic out_free;
  } status_t;

  // Prediction coefficients; unknown filters predict nothing.
  function automatic logic signed [COEF_W-1:0] coef0(input logic [3:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      4'd1:    k = 8'sd60;
      4'd2:    k = 8'sd115;
      4'd3:    k = 8'sd98;
      4'd4:    k = 8'sd122;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef1(input logic [3:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      4'd2:    k = -8'sd52;
      4'd3:    k = -8'sd55;
      4'd4:    k = -8'sd60;
      default: k = 8'sd0;
    endcase
    return k;
  endfunction

endpackage

// ===== src/psadpcm_ctrl.sv =====
module psadpcm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psadpcm_pkg::status_t status,
  output psadpcm_pkg::cmd_t    cmd
);

  psadpcm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psadpcm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psadpcm_pkg::S_IDLE: begin
        if (in_valid) state_next = psadpcm_pkg::S_HEAD;
      end
      psadpcm_pkg::S_HEAD: begin
        state_next = status.has_samples ? psadpcm_pkg::S_MUL0 : psadpcm_pkg::S_IDLE;
      end
      psadpcm_pkg::S_MUL0: state_next = psadpcm_pkg::S_SUM0;
      psadpcm_pkg::S_SUM0: begin
        // hold until the output register can take the word
        if (status.out_free) state_next = psadpcm_pkg::S_MUL1;
      end
      psadpcm_pkg::S_MUL1: state_next = psadpcm_pkg::S_SUM1;
      psadpcm_pkg::S_SUM1: begin
        if (status.out_free) state_next = psadpcm_pkg::S_IDLE;
      end
      default: state_next = psadpcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd           = '0;
    case (state)
      psadpcm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      psadpcm_pkg::S_HEAD: cmd.head = 1'b1;
      psadpcm_pkg::S_MUL0: cmd.mul = 1'b1;
      psadpcm_pkg::S_SUM0: cmd.sum = status.out_free;
      psadpcm_pkg::S_MUL1: begin
        cmd.mul       = 1'b1;
        cmd.hi_nibble = 1'b1;
      end
      psadpcm_pkg::S_SUM1: begin
        cmd.sum       = status.out_free;
        cmd.hi_nibble = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_take_then_head: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == psadpcm_pkg::S_HEAD)
    else $error("accepted word not followed by header step");

  a_sum_waits: assert property (@(posedge clk) disable iff (rst)
    (state == psadpcm_pkg::S_SUM0 && !status.out_free) |=> state == psadpcm_pkg::S_SUM0)
    else $error("first sample dropped while output held");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.head, cmd.mul, cmd.sum}))
    else $error("more than one datapath command at once");

endmodule

// ===== src/psadpcm_dp.sv =====
module psadpcm_dp #(
  parameter int CHANNELS = psadpcm_pkg::DEF_CHANNELS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  psadpcm_pkg::cmd_t                         cmd,
  output psadpcm_pkg::status_t                      status,
  input  logic [psadpcm_pkg::CH_PORT_W-1:0]         channel,
  input  logic [7:0]                                data_byte,
  input  logic                                      new_stream,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [psadpcm_pkg::CH_PORT_W-1:0]         out_channel,
  output logic signed [psadpcm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                      last_of_run,
  output logic                                      block_end
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // per-channel state
  logic signed [psadpcm_pkg::SAMPLE_W-1:0] prev_arr  [CHANNELS];
  logic signed [psadpcm_pkg::SAMPLE_W-1:0] older_arr [CHANNELS];
  logic [3:0]                              pos_arr   [CHANNELS];
  logic [3:0]                              filt_arr  [CHANNELS];
  logic [3:0]                              shift_arr [CHANNELS];
  logic                                    mute_arr  [CHANNELS];

  // latched word and working registers
  logic [psadpcm_pkg::CH_PORT_W-1:0]       ch_reg;
  logic [7:0]                              byte_reg;
  logic                                    new_reg;
  logic [3:0]                              cur_pos;
  logic signed [psadpcm_pkg::SAMPLE_W-1:0] scaled;
  logic signed [psadpcm_pkg::PROD_W-1:0]   prod0;
  logic signed [psadpcm_pkg::PROD_W-1:0]   prod1;
  logic                                    out_valid_next;

  logic [31:0]                             ch_ext;
  logic [CH_W-1:0]                         idx;
  logic                                    ch_ok;
  logic [3:0]                              pos_eff;
  logic                                    mute_flag;
  logic [3:0]                              nib;
  logic signed [psadpcm_pkg::PSUM_W-1:0]   psum;
  logic signed [psadpcm_pkg::PSUM_W-1:0]   psum_adj;
  logic signed [psadpcm_pkg::PRED_W-1:0]   pred;
  logic signed [psadpcm_pkg::SUM_W-1:0]    total;
  logic signed [psadpcm_pkg::SAMPLE_W-1:0] sat;
  logic                                    muted_now;

  assign ch_ext    = 32'(ch_reg);
  assign idx       = ch_ext[CH_W-1:0];
  assign ch_ok     = ch_ext < 32'(CHANNELS);
  assign pos_eff   = new_reg ? psadpcm_pkg::POS_HEADER : pos_arr[idx];
  assign mute_flag = byte_reg[2:0] == psadpcm_pkg::FLAGS_MUTE;
  assign nib       = cmd.hi_nibble ? byte_reg[7:4] : byte_reg[3:0];
  assign muted_now = mute_arr[idx];

  assign status.has_samples = ch_ok && (pos_eff >= psadpcm_pkg::POS_FIRST);
  assign status.out_free    = !out_valid || !out_stall;

  // divide by 64 toward zero: bias negative sums before the shift
  assign psum     = psadpcm_pkg::PSUM_W'(prod0) + psadpcm_pkg::PSUM_W'(prod1);
  assign psum_adj = psum + {{(psadpcm_pkg::PSUM_W-6){1'b0}}, {6{psum[psadpcm_pkg::PSUM_W-1]}}};
  assign pred     = psum_adj[psadpcm_pkg::PSUM_W-1:6];
  assign total    = psadpcm_pkg::SUM_W'(scaled) + psadpcm_pkg::SUM_W'(pred);

  always_comb begin
    if (total > psadpcm_pkg::SUM_W'(psadpcm_pkg::SAMPLE_MAX)) begin
      sat = psadpcm_pkg::SAMPLE_MAX;
    end else if (total < psadpcm_pkg::SUM_W'(psadpcm_pkg::SAMPLE_MIN)) begin
      sat = psadpcm_pkg::SAMPLE_MIN;
    end else begin
      sat = total[psadpcm_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_reg   <= channel;
      byte_reg <= data_byte;
      new_reg  <= new_stream;
    end
    if (cmd.head) begin
      cur_pos <= pos_eff;
    end
    if (cmd.mul) begin
      scaled <= $signed({nib, 12'b0}) >>> shift_arr[idx];
      prod0  <= psadpcm_pkg::PROD_W'(prev_arr[idx]) *
                psadpcm_pkg::PROD_W'(psadpcm_pkg::coef0(filt_arr[idx]));
      prod1  <= psadpcm_pkg::PROD_W'(older_arr[idx]) *
                psadpcm_pkg::PROD_W'(psadpcm_pkg::coef1(filt_arr[idx]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_arr[i]  <= '0;
        older_arr[i] <= '0;
        pos_arr[i]   <= '0;
        filt_arr[i]  <= '0;
        shift_arr[i] <= '0;
        mute_arr[i]  <= 1'b0;
      end
    end else begin
      if (cmd.head && ch_ok) begin
        pos_arr[idx] <= pos_eff + 4'd1;
        if (new_reg) begin
          prev_arr[idx]  <= '0;
          older_arr[idx] <= '0;
          mute_arr[idx]  <= 1'b0;
        end
        if (pos_eff == psadpcm_pkg::POS_HEADER) begin
          filt_arr[idx]  <= byte_reg[7:4];
          shift_arr[idx] <= byte_reg[3:0];
        end
        if (pos_eff == psadpcm_pkg::POS_FLAGS) begin
          mute_arr[idx] <= mute_flag;
          if (mute_flag) begin
            prev_arr[idx]  <= '0;
            older_arr[idx] <= '0;
          end
        end
      end
      if (cmd.sum && !muted_now) begin
        older_arr[idx] <= prev_arr[idx];
        prev_arr[idx]  <= sat;
      end
    end
  end

  assign out_valid_next = cmd.sum || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      out_channel <= ch_reg;
      sample      <= muted_now ? '0 : sat;
      last_of_run <= cmd.hi_nibble;
      block_end   <= cmd.hi_nibble && (cur_pos == psadpcm_pkg::POS_LAST);
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!block_end || last_of_run))
    else $error("block end flagged on first sample of a byte");

  a_mul_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> (cur_pos >= psadpcm_pkg::POS_FIRST))
    else $error("sample decode on a header byte");

  a_muted_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum && muted_now) |=> (sample == '0))
    else $error("muted block gave a nonzero sample");

  a_sum_free: assert property (@(posedge clk) disable iff (rst)
    cmd.sum |-> status.out_free)
    else $error("output register overwritten while held");

endmodule

// ===== src/ps_adpcm_block_decoder.sv =====
// PS-ADPCM block decoder for interleaved channels.
// Input: one raw byte per word (channel, data_byte, new_stream) on in_valid /
// in_stall. Each channel walks its own 16-byte block: byte 0 sets filter and
// shift, byte 1 the flags (7 mutes the block), bytes 2..15 give two samples.
// Output: one sample per word on out_valid / out_stall, with out_channel,
// last_of_run on the second sample of a byte and block_end on the 28th.
// Steps: a header byte is accepted, then its state is looked up. A data byte
// goes through accept, state lookup, then multiply and accumulate for each of
// its two samples, one at a time through the shared two-coefficient multiply /
// saturate path. The output register takes each sample at the end of its
// accumulate step. Bytes for channels at or above CHANNELS are dropped.
// While out_stall is high the sample is held in the output register and the
// decoder waits before producing the next one; in_stall stays high while a
// byte is in work. Reset clears every channel's history, position, filter,
// shift and mute mark, and empties the output register.
module ps_adpcm_block_decoder #(
  parameter int CHANNELS = psadpcm_pkg::DEF_CHANNELS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [psadpcm_pkg::CH_PORT_W-1:0]       channel,
  input  logic [7:0]                              data_byte,
  input  logic                                    new_stream,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [psadpcm_pkg::CH_PORT_W-1:0]       out_channel,
  output logic signed [psadpcm_pkg::SAMPLE_W-1:0] sample,
  output logic                                    last_of_run,
  output logic                                    block_end
);

  psadpcm_pkg::cmd_t    cmd;
  psadpcm_pkg::status_t status;

  psadpcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  psadpcm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .channel     (channel),
    .data_byte   (data_byte),
    .new_stream  (new_stream),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_channel (out_channel),
    .sample      (sample),
    .last_of_run (last_of_run),
    .block_end   (block_end)
  );

endmodule
